// File: hdl/ofrs_pkg.sv
// Shared types and constants for the OLED framebuffer refresh streamer.
// No dependencies.
package ofrs_pkg;

  // Default display geometry
  localparam int DISP_WIDTH_DEF  = 128;
  localparam int DISP_HEIGHT_DEF = 64;

  // Bus constants
  localparam logic [7:0] ADDR_BYTE_RESET = 8'h78;
  localparam logic [7:0] CTRL_CMD        = 8'h00;
  localparam logic [7:0] CTRL_DATA       = 8'h40;
  localparam logic [7:0] CMD_PAGE_BASE   = 8'hB0;
  localparam logic [7:0] CMD_COL_LO      = 8'h00;
  localparam logic [7:0] CMD_COL_HI      = 8'h10;

  // Transaction phases within one page
  localparam logic [1:0] PH_PAGE  = 2'd0;
  localparam logic [1:0] PH_COLLO = 2'd1;
  localparam logic [1:0] PH_COLHI = 2'd2;
  localparam logic [1:0] PH_DATA  = 2'd3;

  // Request opcodes
  typedef enum logic [1:0] {
    OP_PIXEL   = 2'd0,
    OP_CLEAR   = 2'd1,
    OP_REFRESH = 2'd2,
    OP_TICK    = 2'd3
  } ofrs_op_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] pixel_x;
    logic [7:0] pixel_y;
    logic       pixel_on;
  } ofrs_in_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] bus_byte;
    logic       transaction_start;
    logic       transaction_end;
    logic       refresh_busy;
    logic       rejected;
  } ofrs_out_t;

endpackage

// File: hdl/ofrs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ofrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// File: hdl/oled_framebuffer_refresh_streamer_top.sv
// Top level: page framebuffer, pixel/clear sequencer and bus refresh streamer.
// Depends on ofrs_pkg and ofrs_ram.
// Pixel, refresh and tick requests give their result strobe the cycle after acceptance,
//   set by the ST_RESP state register; a clear gives its strobe after the clearing sweep.
// A new request is taken only once the last one is through (busy until then); a clear
//   holds busy through a sweep that zeroes the store, one store byte written per cycle.
//   The result strobe cannot be stalled.
// Reset (rst_n low, synchronous): busy stays high for a clearing pass over all
//   DISPLAY_WIDTH*pages bytes (1024 by default) that zeroes the store; no result follows it.
module oled_framebuffer_refresh_streamer_top #(
  parameter int DISPLAY_WIDTH  = ofrs_pkg::DISP_WIDTH_DEF,
  parameter int DISPLAY_HEIGHT = ofrs_pkg::DISP_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  ofrs_pkg::ofrs_in_t in_payload,
  output logic               out_valid,
  output ofrs_pkg::ofrs_out_t out_payload,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata
);

  import ofrs_pkg::*;

  localparam int PAGE_COUNT  = (DISPLAY_HEIGHT + 7) / 8;
  localparam int STORE_DEPTH = DISPLAY_WIDTH * PAGE_COUNT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int PG_W        = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int DATA_LEN    = DISPLAY_WIDTH + 2;
  localparam int CMD_LEN     = 3;
  localparam int POS_W       = $clog2(DATA_LEN);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RESP  = 3'b010,
    ST_CLEAR = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   clr_addr_r, clr_addr_nxt;
  logic                clr_resp_r, clr_resp_nxt;
  logic                active_r, active_nxt;
  logic [PG_W-1:0]     page_r, page_nxt;
  logic [1:0]          phase_r, phase_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [7:0]          addr_byte_r;

  ofrs_out_t           resp_r, resp_nxt;
  logic                data_sel_r, data_sel_nxt;
  logic                pix_wr_r, pix_wr_nxt;
  logic [ADDR_W-1:0]   pix_addr_r, pix_addr_nxt;
  logic [7:0]          pix_mask_r, pix_mask_nxt;
  logic                pix_on_r, pix_on_nxt;

  logic                accept;
  logic                in_range;
  logic [ADDR_W-1:0]   pix_addr;
  logic [ADDR_W-1:0]   data_addr;
  logic [POS_W-1:0]    len_last;
  logic [7:0]          tick_byte;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [7:0]          ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [7:0]          ram_rdata;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  // Address arithmetic for pixel and stream data reads
  assign in_range  = ({1'b0, in_payload.pixel_x} < 9'(DISPLAY_WIDTH)) &&
                     ({1'b0, in_payload.pixel_y} < 9'(DISPLAY_HEIGHT));
  assign pix_addr  = ADDR_W'(32'(in_payload.pixel_y[7:3]) * DISPLAY_WIDTH +
                             32'(in_payload.pixel_x));
  assign data_addr = ADDR_W'(32'(page_r) * DISPLAY_WIDTH + 32'(pos_r) - 2);
  assign len_last  = (phase_r == PH_DATA) ? POS_W'(DATA_LEN - 1) : POS_W'(CMD_LEN - 1);

  // Non-data stream byte for the current position
  always_comb begin
    if (pos_r == POS_W'(0)) begin
      tick_byte = addr_byte_r;
    end else if (pos_r == POS_W'(1)) begin
      tick_byte = (phase_r == PH_DATA) ? CTRL_DATA : CTRL_CMD;
    end else begin
      case (phase_r)
        PH_PAGE:  tick_byte = CMD_PAGE_BASE + 8'(page_r);
        PH_COLLO: tick_byte = CMD_COL_LO;
        PH_COLHI: tick_byte = CMD_COL_HI;
        default:  tick_byte = 8'h00;
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    clr_resp_nxt = clr_resp_r;
    active_nxt   = active_r;
    page_nxt     = page_r;
    phase_nxt    = phase_r;
    pos_nxt      = pos_r;
    resp_nxt     = resp_r;
    data_sel_nxt = data_sel_r;
    pix_wr_nxt   = pix_wr_r;
    pix_addr_nxt = pix_addr_r;
    pix_mask_nxt = pix_mask_r;
    pix_on_nxt   = pix_on_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          resp_nxt     = '0;
          data_sel_nxt = 1'b0;
          pix_wr_nxt   = 1'b0;
          pix_addr_nxt = pix_addr;
          pix_mask_nxt = 8'(1) << in_payload.pixel_y[2:0];
          pix_on_nxt   = in_payload.pixel_on;
          state_nxt    = ST_RESP;
          unique case (ofrs_op_t'(in_payload.op))
            OP_PIXEL, OP_CLEAR: begin
              if (active_r) begin
                resp_nxt.rejected = 1'b1;
              end else if (in_payload.op == OP_CLEAR) begin
                clr_addr_nxt = '0;
                clr_resp_nxt = 1'b1;
                state_nxt    = ST_CLEAR;
              end else begin
                pix_wr_nxt = in_range;
              end
            end
            OP_REFRESH: begin
              if (!active_r) begin
                active_nxt = 1'b1;
                page_nxt   = '0;
                phase_nxt  = PH_PAGE;
                pos_nxt    = '0;
              end
            end
            OP_TICK: begin
              if (active_r) begin
                resp_nxt.byte_valid        = 1'b1;
                resp_nxt.bus_byte          = tick_byte;
                resp_nxt.transaction_start = (pos_r == POS_W'(0));
                resp_nxt.transaction_end   = (pos_r == len_last);
                data_sel_nxt = (phase_r == PH_DATA) && (pos_r >= POS_W'(2));
                if (pos_r == len_last) begin
                  pos_nxt = '0;
                  if (phase_r == PH_DATA) begin
                    phase_nxt = PH_PAGE;
                    if (page_r == PG_W'(PAGE_COUNT - 1)) begin
                      page_nxt   = '0;
                      active_nxt = 1'b0;
                    end else begin
                      page_nxt = page_r + PG_W'(1);
                    end
                  end else begin
                    phase_nxt = phase_r + 2'd1;
                  end
                end else begin
                  pos_nxt = pos_r + POS_W'(1);
                end
              end
            end
            default: ;
          endcase
          resp_nxt.refresh_busy = active_nxt;
        end
      end
      ST_RESP: begin
        pix_wr_nxt = 1'b0;
        state_nxt  = ST_IDLE;
      end
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == ADDR_W'(STORE_DEPTH - 1)) begin
          clr_addr_nxt = '0;
          clr_resp_nxt = 1'b0;
          state_nxt    = clr_resp_r ? ST_RESP : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
      clr_resp_r <= 1'b0;
      active_r   <= 1'b0;
      page_r     <= '0;
      phase_r    <= PH_PAGE;
      pos_r      <= '0;
      pix_wr_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      clr_resp_r <= clr_resp_nxt;
      active_r   <= active_nxt;
      page_r     <= page_nxt;
      phase_r    <= phase_nxt;
      pos_r      <= pos_nxt;
      pix_wr_r   <= pix_wr_nxt;
    end
  end

  // Result and pixel payload registers
  always_ff @(posedge clk) begin
    resp_r     <= resp_nxt;
    data_sel_r <= data_sel_nxt;
    pix_addr_r <= pix_addr_nxt;
    pix_mask_r <= pix_mask_nxt;
    pix_on_r   <= pix_on_nxt;
  end

  // Bus address register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_byte_r <= ADDR_BYTE_RESET;
    end else if (cfg_we) begin
      addr_byte_r <= cfg_wdata;
    end
  end

  // Store port muxing: clearing sweep or pixel read-modify-write
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pix_addr_r;
    ram_wdata = pix_on_r ? (ram_rdata | pix_mask_r) : (ram_rdata & ~pix_mask_r);
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = 8'h00;
    end else if (state_r == ST_RESP) begin
      ram_we = pix_wr_r;
    end
  end

  assign ram_raddr = (in_payload.op == OP_PIXEL) ? pix_addr : data_addr;

  ofrs_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Result ports
  assign out_valid = (state_r == ST_RESP);
  always_comb begin
    out_payload = resp_r;
    if (data_sel_r) begin
      out_payload.bus_byte = ram_rdata;
    end
  end

`ifndef ASSERT_OFF
  a_resp_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_payload.op != OP_CLEAR) |=> out_valid)
    else $error("result strobe missing after request");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload.rejected |-> out_payload.refresh_busy)
    else $error("request rejected while no refresh runs");
`endif

endmodule
